// ===== sv/etf_pkg.sv =====
// Shared types, constants and defaults for the escape-time fractal iterator.
package etf_pkg;

    localparam int DEF_FRACTION_BITS = 28;
    localparam int DEF_COUNT_WIDTH   = 16;

    localparam int DATA_W     = 32;
    localparam int MAX_ITER_W = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int ZW         = DATA_W + 1;
    localparam int PW         = 2 * ZW;
    localparam int WW         = PW + 2;
    localparam int SW         = PW + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_JC_REAL  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_JC_IMAG  = CFG_IDX_W'(3);

    localparam logic [MODE_W-1:0] MODE_MANDEL = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_JULIA  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_SHIP   = MODE_W'(2);

    localparam logic [MAX_ITER_W-1:0] RST_MAX_ITER = MAX_ITER_W'(100);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_R,
        ST_SQ_I,
        ST_CROSS,
        ST_UPDATE
    } etf_state_t;

    typedef enum logic [1:0] {
        MUL_RR,
        MUL_II,
        MUL_RI
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     cap_rr;
        logic     cap_ii;
        logic     upd_z;
    } etf_ctrl_t;

    typedef struct packed {
        logic abs_esc;
        logic sq_esc;
    } etf_status_t;

    typedef struct packed {
        logic                  finish;
        logic                  esc;
        logic [MAX_ITER_W-1:0] count;
    } etf_res_t;

endpackage

// ===== sv/etf_mul.sv =====
// Shared signed multiplier with operand select and registered product.
module etf_mul (
    input  logic                         clk,
    input  etf_pkg::mul_sel_t            sel,
    input  logic signed [etf_pkg::ZW-1:0] zr,
    input  logic signed [etf_pkg::ZW-1:0] zi,
    output logic signed [etf_pkg::PW-1:0] prod
);
    import etf_pkg::*;

    logic signed [ZW-1:0] op_a;
    logic signed [ZW-1:0] op_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;

    always_comb
    begin
        case (sel)
            MUL_RR:
            begin
                op_a = zr;
                op_b = zr;
            end
            MUL_II:
            begin
                op_a = zi;
                op_b = zi;
            end
            MUL_RI:
            begin
                op_a = zr;
                op_b = zi;
            end
            default:
            begin
                op_a = zr;
                op_b = zi;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/etf_fsm.sv =====
// Iteration sequencer: drives the shared multiplier and counts iterations.
module etf_fsm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start_ok,
    input  logic [etf_pkg::MAX_ITER_W-1:0]    max_iter,
    input  etf_pkg::etf_status_t              status,
    output etf_pkg::etf_ctrl_t                ctrl,
    output etf_pkg::etf_res_t                 res,
    output logic                              busy
);
    import etf_pkg::*;

    etf_state_t            state_reg;
    etf_state_t            state_next;
    logic [MAX_ITER_W-1:0] count_reg;
    logic [MAX_ITER_W-1:0] count_next;
    logic                  first_reg;
    logic                  first_next;
    logic [MAX_ITER_W-1:0] count_inc;
    logic                  limit_hit;

    assign count_inc = count_reg + MAX_ITER_W'(1);
    assign limit_hit = (count_inc == max_iter);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        first_next = first_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_ok && (max_iter != '0))
                begin
                    state_next = ST_SQ_R;
                    count_next = '0;
                    first_next = 1'b1;
                end
            end
            ST_SQ_R:
                state_next = ST_SQ_I;
            ST_SQ_I:
                state_next = ST_CROSS;
            ST_CROSS:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    state_next = ST_UPDATE;
                end
                else if (status.sq_esc || limit_hit)
                    state_next = ST_IDLE;
                else
                begin
                    count_next = count_inc;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.abs_esc)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SQ_R;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl         = '0;
        ctrl.mul_sel = MUL_RR;
        res          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.load = start_ok;
                if (start_ok && (max_iter == '0))
                    res.finish = 1'b1;
            end
            ST_SQ_R:
                ctrl.mul_sel = MUL_RR;
            ST_SQ_I:
            begin
                ctrl.mul_sel = MUL_II;
                ctrl.cap_rr  = 1'b1;
            end
            ST_CROSS:
            begin
                ctrl.mul_sel = MUL_RI;
                ctrl.cap_ii  = 1'b1;
                if (!first_reg)
                begin
                    if (status.sq_esc)
                    begin
                        res.finish = 1'b1;
                        res.esc    = 1'b1;
                        res.count  = count_reg;
                    end
                    else if (limit_hit)
                    begin
                        res.finish = 1'b1;
                        res.count  = count_inc;
                    end
                end
            end
            ST_UPDATE:
            begin
                ctrl.upd_z = 1'b1;
                if (status.abs_esc)
                begin
                    res.finish = 1'b1;
                    res.esc    = 1'b1;
                    res.count  = count_reg;
                end
            end
            default:
                ctrl.mul_sel = MUL_RR;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== sv/escape_time_fractal_iterator.sv =====
// Top level of the escape-time fractal iterator: config, datapath and result.
//
// One point is taken per request when start is high and busy is low. Each iteration of
// z = z^2 + c runs on the single shared 33x33 multiplier in steps (zr*zr, zi*zi,
// zr*zi, then the update). The number of iterations run is the escaping iteration
// index plus one, or max_iterations. Busy drops after the update step when the escape
// shows as a coordinate beyond two; when it shows only in the squared magnitude or when
// the limit ends the run, busy stays high into the next pass, since that test waits for
// the zr*zi step of that pass. The result strobe rises in the cycle busy drops. A limit
// of zero never raises busy and gives a result in the cycle after the request. The
// strobe done is high for exactly one cycle and cannot be held off; iteration_count and
// escaped hold their values until the next result. A new request may be issued in the
// cycle done is high. Configuration writes are always ready and must only be issued while
// the block is idle.
module escape_time_fractal_iterator #(
    parameter int FRACTION_BITS = etf_pkg::DEF_FRACTION_BITS,
    parameter int COUNT_WIDTH   = etf_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [etf_pkg::DATA_W-1:0]     point_real,
    input  logic signed [etf_pkg::DATA_W-1:0]     point_imag,
    output logic                                  done,
    output logic [COUNT_WIDTH-1:0]                iteration_count,
    output logic                                  escaped,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [etf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [etf_pkg::DATA_W-1:0]            cfg_data
);
    import etf_pkg::*;

    localparam int CEXT = (COUNT_WIDTH > MAX_ITER_W) ? COUNT_WIDTH : MAX_ITER_W;
    localparam logic signed [WW-1:0] ESC_LIM =
        {{(WW-1){1'b0}}, 1'b1} << (FRACTION_BITS + 1);
    localparam logic signed [WW-1:0] ESC_NEG = -ESC_LIM;
    localparam logic [SW-1:0] SQ_LIM = {{(SW-1){1'b0}}, 1'b1} << (2 * FRACTION_BITS + 2);

    logic [MODE_W-1:0]     mode_reg;
    logic [MAX_ITER_W-1:0] max_iter_reg;
    logic signed [DATA_W-1:0] jc_re_reg;
    logic signed [DATA_W-1:0] jc_im_reg;

    logic signed [ZW-1:0]     zr_reg;
    logic signed [ZW-1:0]     zr_next;
    logic signed [ZW-1:0]     zi_reg;
    logic signed [ZW-1:0]     zi_next;
    logic signed [DATA_W-1:0] cr_reg;
    logic signed [DATA_W-1:0] cr_next;
    logic signed [DATA_W-1:0] ci_reg;
    logic signed [DATA_W-1:0] ci_next;
    logic signed [PW-1:0]     rr_reg;
    logic signed [PW-1:0]     ii_reg;

    logic                     done_reg;
    logic [COUNT_WIDTH-1:0]   count_out_reg;
    logic                     escaped_reg;

    logic                     start_ok;
    logic                     is_julia;
    logic                     is_ship;
    logic signed [PW-1:0]     prod;
    logic signed [PW-1:0]     cross_abs;
    logic signed [WW-1:0]     sq_diff;
    logic signed [WW-1:0]     nr;
    logic signed [WW-1:0]     ni;
    logic [SW-1:0]            mag_sum;
    logic [CEXT-1:0]          count_ext;

    etf_ctrl_t   ctrl;
    etf_status_t status;
    etf_res_t    res;

    assign start_ok  = start && !busy;
    assign is_julia  = (mode_reg == MODE_JULIA);
    assign is_ship   = (mode_reg == MODE_SHIP);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_MANDEL;
            max_iter_reg <= RST_MAX_ITER;
            jc_re_reg    <= '0;
            jc_im_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:     mode_reg     <= cfg_data[MODE_W-1:0];
                CFG_MAX_ITER: max_iter_reg <= cfg_data[MAX_ITER_W-1:0];
                CFG_JC_REAL:  jc_re_reg    <= cfg_data;
                CFG_JC_IMAG:  jc_im_reg    <= cfg_data;
                default:      mode_reg     <= mode_reg;
            endcase
        end
    end

    etf_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .start_ok (start_ok),
        .max_iter (max_iter_reg),
        .status   (status),
        .ctrl     (ctrl),
        .res      (res),
        .busy     (busy)
    );

    etf_mul u_mul (
        .clk  (clk),
        .sel  (ctrl.mul_sel),
        .zr   (zr_reg),
        .zi   (zi_reg),
        .prod (prod)
    );

    always_comb
    begin
        if (is_ship && prod[PW-1])
            cross_abs = -prod;
        else
            cross_abs = prod;
    end

    assign sq_diff = WW'(rr_reg) - WW'(ii_reg);
    assign nr      = (sq_diff >>> FRACTION_BITS) + WW'(cr_reg);
    assign ni      = (WW'(cross_abs) >>> (FRACTION_BITS - 1)) + WW'(ci_reg);
    assign mag_sum = SW'($unsigned(rr_reg)) + SW'($unsigned(prod));

    assign status.abs_esc = (nr > ESC_LIM) || (nr < ESC_NEG) ||
                            (ni > ESC_LIM) || (ni < ESC_NEG);
    assign status.sq_esc  = (mag_sum > SQ_LIM);

    always_comb
    begin
        zr_next = zr_reg;
        zi_next = zi_reg;
        cr_next = cr_reg;
        ci_next = ci_reg;
        if (ctrl.load)
        begin
            if (is_julia)
            begin
                zr_next = ZW'(point_real);
                zi_next = ZW'(point_imag);
                cr_next = jc_re_reg;
                ci_next = jc_im_reg;
            end
            else
            begin
                zr_next = '0;
                zi_next = '0;
                cr_next = point_real;
                ci_next = point_imag;
            end
        end
        else if (ctrl.upd_z)
        begin
            zr_next = nr[ZW-1:0];
            zi_next = ni[ZW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg <= zr_next;
        zi_reg <= zi_next;
        cr_reg <= cr_next;
        ci_reg <= ci_next;
        if (ctrl.cap_rr)
            rr_reg <= prod;
        if (ctrl.cap_ii)
            ii_reg <= prod;
    end

    assign count_ext = CEXT'(res.count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            count_out_reg <= '0;
            escaped_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= res.finish;
            if (res.finish)
            begin
                count_out_reg <= count_ext[COUNT_WIDTH-1:0];
                escaped_reg   <= res.esc;
            end
        end
    end

    assign done            = done_reg;
    assign iteration_count = count_out_reg;
    assign escaped         = escaped_reg;

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result strobe without a request");

    a_esc_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (res.finish && res.esc) |-> (res.count < max_iter_reg))
        else $error("escape count reached the limit");

    a_bounded_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (res.finish && !res.esc) |-> (res.count == max_iter_reg))
        else $error("bounded result differs from the limit");
`endif

endmodule
